// File: sv/ffpa_pkg.sv
// Package for the first-fit partition allocator: item types, status codes, states.
// No dependencies.
package ffpa_pkg;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_NOADDR = 2'd3;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam int SIZE_W = 16;

	typedef struct packed {
		logic              func;
		logic [SIZE_W-1:0] request_size;
		logic [SIZE_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SIZE_W-1:0] alloc_addr;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_SHR,
		S_SHW,
		S_SPLIT,
		S_NB_RD,
		S_NB_CHK,
		S_PV_CHK,
		S_CL_RD,
		S_CL_WR,
		S_DONE
	} state_t;

endpackage

// File: sv/ffpa_tbl.sv
// Partition table memory: one entry holds start, length and used mark.
// Depends on ffpa_pkg. Synchronous write, one read port with registered data.
module ffpa_tbl
	import ffpa_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 16,
	parameter int IW    = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [IW-1:0]   waddr,
	input  logic [2*AW:0]   wdata,
	input  logic [IW-1:0]   raddr,
	output logic [2*AW:0]   rdata
);
	logic [2*AW:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/first_fit_partition_allocator_top.sv
// First-fit partition allocator, top level: sequencer around the partition table.
// Depends on ffpa_pkg and ffpa_tbl.
//
// Each item is one allocate or free request and yields exactly one result, shown
// with done high for a single cycle, unless total_size is written while it runs;
// the receiver cannot stall, so busy alone throttles the input. A zero-size
// allocate is answered without a table read. The table lives in a memory with one
// registered read port, read one entry per cycle, so the first-fit or address scan
// spends a read state and a check state on each entry visited. A split moves the
// following entries up one place with a read and a write each. A free that merges
// with both neighbors near the front of the table closes the gap twice, once per
// absorbed entry, which is the slowest case. Writing total_size resets the table
// to one free partition at once (count register reset, entry 0 written the next
// cycle); entries beyond the count are never read.
module first_fit_partition_allocator_top
	import ffpa_pkg::*;
#(
	parameter int MAX_PARTS = 32,
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  req_t                 req,
	output logic                 busy,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [SIZE_W-1:0]    cfg_wdata
);
	localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int CW = $clog2(MAX_PARTS + 1);
	localparam int EW = 2 * ADDR_BITS + 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARTS);

	// entry fields: {used, start, length}
	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] idx_q, idx_d;     // entry under work
	logic [IW-1:0] mv_q, mv_d;       // shift cursor
	logic          func_q;
	logic [ADDR_BITS-1:0] arg_q;     // size or address of the item
	logic [ADDR_BITS-1:0] st_q, st_d;  // start of found entry
	logic [ADDR_BITS-1:0] ln_q, ln_d;  // length of found entry
	logic [1:0]    stat_q, stat_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic          init_q, init_d;   // write the fresh entry 0
	logic [ADDR_BITS-1:0] tot_q;
	logic          hold_q, hold_d;   // merge with predecessor still pending
	logic          pvm_q, pvm_d;     // gap close after predecessor merge underway
	logic [ADDR_BITS-1:0] pst_q, pst_d; // predecessor start
	logic [ADDR_BITS-1:0] pln_q, pln_d; // predecessor length
	logic          pfree_q, pfree_d;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic          r_used;
	logic [ADDR_BITS-1:0] r_st, r_ln;

	assign r_used = rdata[EW-1];
	assign r_st   = rdata[2*ADDR_BITS-1:ADDR_BITS];
	assign r_ln   = rdata[ADDR_BITS-1:0];

	ffpa_tbl #(.DEPTH(MAX_PARTS), .AW(ADDR_BITS), .IW(IW)) u_tbl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= CW'(1);
			init_q  <= 1'b1;
			tot_q   <= ADDR_BITS'(1024);
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			init_q  <= init_d;
			done    <= (state_d == S_DONE);
			if (cfg_we) begin
				tot_q <= ADDR_BITS'(cfg_wdata);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		mv_q   <= mv_d;
		st_q   <= st_d;
		ln_q   <= ln_d;
		stat_q <= stat_d;
		addr_q <= addr_d;
		hold_q <= hold_d;
		pvm_q  <= pvm_d;
		pst_q  <= pst_d;
		pln_q  <= pln_d;
		pfree_q <= pfree_d;
		if (start && !busy) begin
			func_q <= req.func;
			arg_q  <= (req.func == FUNC_FREE) ? ADDR_BITS'(req.free_addr)
			                                  : ADDR_BITS'(req.request_size);
		end
	end

	assign busy = (state_q != S_IDLE) || init_q || cfg_we;
	assign rsp.status     = stat_q;
	assign rsp.alloc_addr = SIZE_W'(addr_q);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		mv_d    = mv_q;
		st_d    = st_q;
		ln_d    = ln_q;
		stat_d  = stat_q;
		addr_d  = addr_q;
		hold_d  = hold_q;
		pvm_d   = pvm_q;
		pst_d   = pst_q;
		pln_d   = pln_q;
		pfree_d = pfree_q;
		init_d  = init_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = '0;
		raddr   = idx_q;
		if (cfg_we) begin
			// reset the table: count back to one, entry 0 written next cycle
			cnt_d   = CW'(1);
			init_d  = 1'b1;
			state_d = S_IDLE;
		end else if (init_q) begin
			we     = 1'b1;
			waddr  = '0;
			wdata  = {1'b0, {ADDR_BITS{1'b0}}, tot_q};
			init_d = 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_d   = '0;
						addr_d  = '0;
						pfree_d = 1'b0;
						pvm_d   = 1'b0;
						if (req.func == FUNC_ALLOC && req.request_size == '0) begin
							stat_d  = ST_NOFIT;
							state_d = S_DONE;
						end else begin
							state_d = S_RD;
						end
					end
				end
				S_RD: begin
					raddr   = idx_q;
					state_d = S_CHK;
				end
				S_CHK: begin
					// examine the entry read last cycle
					st_d = r_st;
					ln_d = r_ln;
					if (func_q == FUNC_ALLOC) begin
						if (!r_used && r_ln == arg_q) begin
							we     = 1'b1;
							wdata  = {1'b1, r_st, r_ln};
							stat_d = ST_OK;
							addr_d = r_st;
							state_d = S_DONE;
						end else if (!r_used && r_ln > arg_q) begin
							if (cnt_q >= CNT_MAX) begin
								stat_d  = ST_FULL;
								state_d = S_DONE;
							end else begin
								// open a gap after idx by moving entries up
								mv_d    = IW'(cnt_q - CW'(1));
								state_d = (IW'(cnt_q - CW'(1)) == idx_q) ? S_SPLIT : S_SHR;
							end
						end else if (CW'(idx_q) + CW'(1) >= cnt_q) begin
							stat_d  = ST_NOFIT;
							state_d = S_DONE;
						end else begin
							idx_d   = idx_q + IW'(1);
							state_d = S_RD;
						end
					end else begin
						if (r_used && r_st == arg_q) begin
							hold_d = pfree_q && (idx_q != '0);
							if (CW'(idx_q) + CW'(1) < cnt_q) begin
								raddr   = idx_q + IW'(1);
								state_d = S_NB_CHK;
							end else begin
								state_d = S_PV_CHK;
							end
						end else if (CW'(idx_q) + CW'(1) >= cnt_q) begin
							stat_d  = ST_NOADDR;
							state_d = S_DONE;
						end else begin
							pfree_d = !r_used;
							pst_d   = r_st;
							pln_d   = r_ln;
							idx_d   = idx_q + IW'(1);
							state_d = S_RD;
						end
					end
				end
				S_SHR: begin
					raddr   = mv_q;
					state_d = S_SHW;
				end
				S_SHW: begin
					we    = 1'b1;
					waddr = mv_q + IW'(1);
					wdata = rdata;
					mv_d  = mv_q - IW'(1);
					state_d = (mv_q - IW'(1) == idx_q) ? S_SPLIT : S_SHR;
				end
				S_SPLIT: begin
					// write used head now, free tail in S_NB_RD slot
					we     = 1'b1;
					waddr  = idx_q;
					wdata  = {1'b1, st_q, arg_q};
					cnt_d  = cnt_q + CW'(1);
					stat_d = ST_OK;
					addr_d = st_q;
					state_d = S_NB_RD;
				end
				S_NB_RD: begin
					we    = 1'b1;
					waddr = idx_q + IW'(1);
					wdata = {1'b0, st_q + arg_q, ln_q - arg_q};
					state_d = S_DONE;
				end
				S_NB_CHK: begin
					// successor read; absorb it if free
					if (!r_used) begin
						ln_d   = ln_q + r_ln;
						mv_d   = idx_q + IW'(1);
						cnt_d  = cnt_q - CW'(1);
						state_d = (CW'(idx_q) + CW'(2) >= cnt_q) ? S_PV_CHK : S_CL_RD;
					end else begin
						state_d = S_PV_CHK;
					end
				end
				S_CL_RD: begin
					raddr   = mv_q + IW'(1);
					state_d = S_CL_WR;
				end
				S_CL_WR: begin
					we    = 1'b1;
					waddr = mv_q;
					wdata = rdata;
					mv_d  = mv_q + IW'(1);
					// gap closed: finish if it came from the predecessor merge, else check the predecessor
					if (CW'(mv_q) + CW'(2) >= cnt_q + CW'(1)) begin
						state_d = pvm_q ? S_DONE : S_PV_CHK;
					end else begin
						state_d = S_CL_RD;
					end
				end
				S_PV_CHK: begin
					stat_d = ST_OK;
					we     = 1'b1;
					if (hold_q) begin
						// merge into the free predecessor, then close gap at idx
						waddr  = idx_q - IW'(1);
						wdata  = {1'b0, pst_q, pln_q + ln_q};
						hold_d = 1'b0;
						pvm_d  = 1'b1;
						cnt_d  = cnt_q - CW'(1);
						mv_d   = idx_q;
						state_d = (CW'(idx_q) + CW'(1) >= cnt_q) ? S_DONE : S_CL_RD;
					end else begin
						waddr   = idx_q;
						wdata   = {1'b0, st_q, ln_q};
						state_d = S_DONE;
					end
				end
				S_DONE: begin
					state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/ffpa_chk.sv
// Port-level checks for the first-fit partition allocator.
// Depends on ffpa_pkg; bound to first_fit_partition_allocator_top.
module ffpa_chk
	import ffpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> rsp.alloc_addr == '0)
		else $error("address on failure");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy)) else $error("result without item");
endmodule

bind first_fit_partition_allocator_top ffpa_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// File: verif/ffpa_checker.sv
`timescale 1ns / 100ps
// Checker for the first-fit partition allocator: predicts each result from its own
// partition table and compares it with what the block shows. Depends on ffpa_pkg.
module ffpa_checker
	import ffpa_pkg::*;
#(
	parameter int MAX_PARTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  req_t              req,
	input  logic              done,
	input  rsp_t              rsp,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	output int                fail_count,
	output int                pending
);

	logic [SIZE_W-1:0] seg_start [MAX_PARTS];
	logic [SIZE_W-1:0] seg_len [MAX_PARTS];
	logic              seg_used [MAX_PARTS];
	int                seg_count;
	rsp_t              rsp_queue [$];

	function automatic void table_clear(logic [SIZE_W-1:0] sz);
		for (int k = 0; k < MAX_PARTS; k++) begin
			seg_start[k] = '0;
			seg_len[k] = '0;
			seg_used[k] = 1'b0;
		end
		seg_len[0] = sz;
		seg_count = 1;
	endfunction

	function automatic void seg_drop(int idx);
		for (int k = idx; k + 1 < seg_count; k++) begin
			seg_start[k] = seg_start[k+1];
			seg_len[k] = seg_len[k+1];
			seg_used[k] = seg_used[k+1];
		end
		seg_count--;
	endfunction

	function automatic rsp_t predict_result(req_t r);
		rsp_t o;
		int   i;
		o.status = ST_NOFIT;
		o.alloc_addr = '0;
		if (r.func == FUNC_ALLOC) begin
			if (r.request_size != 0) begin
				for (i = 0; i < seg_count; i++) begin
					if (seg_used[i] || seg_len[i] < r.request_size) continue;
					if (seg_len[i] == r.request_size) begin
						seg_used[i] = 1'b1;
						o.status = ST_OK;
						o.alloc_addr = seg_start[i];
					end else if (seg_count >= MAX_PARTS) begin
						o.status = ST_FULL;
					end else begin
						for (int k = seg_count; k > i + 1; k--) begin
							seg_start[k] = seg_start[k-1];
							seg_len[k] = seg_len[k-1];
							seg_used[k] = seg_used[k-1];
						end
						seg_start[i+1] = seg_start[i] + r.request_size;
						seg_len[i+1] = seg_len[i] - r.request_size;
						seg_used[i+1] = 1'b0;
						seg_len[i] = r.request_size;
						seg_used[i] = 1'b1;
						seg_count++;
						o.status = ST_OK;
						o.alloc_addr = seg_start[i];
					end
					break;
				end
			end
		end else begin
			o.status = ST_NOADDR;
			for (i = 0; i < seg_count; i++)
				if (seg_used[i] && seg_start[i] == r.free_addr) break;
			if (i < seg_count) begin
				o.status = ST_OK;
				seg_used[i] = 1'b0;
				if (i + 1 < seg_count && !seg_used[i+1]) begin
					seg_len[i] = seg_len[i] + seg_len[i+1];
					seg_drop(i + 1);
				end
				if (i > 0 && !seg_used[i-1]) begin
					seg_len[i-1] = seg_len[i-1] + seg_len[i];
					seg_drop(i);
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending = rsp_queue.size();

	initial begin
		fail_count = 0;
		table_clear(16'd1024);
	end

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			table_clear(16'd1024);
			rsp_queue.delete();
		end else begin
			if (done) begin
				if (rsp_queue.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = rsp_queue.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.alloc_addr !== want.alloc_addr)
						report_mismatch("alloc_addr", rsp.alloc_addr, want.alloc_addr);
				end
			end
			if (cfg_we)
				table_clear(cfg_wdata);
			if (start && !busy)
				rsp_queue.insert(rsp_queue.size(), predict_result(req));
		end
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the first-fit partition allocator: clock, reset, stimulus and
// verdict. Depends on ffpa_pkg, first_fit_partition_allocator_top and ffpa_checker.
module tb;
	import ffpa_pkg::*;

	localparam int MAX_PARTS = 32;

	logic              clk;
	logic              arst_n;
	logic              start;
	req_t              req;
	logic              busy;
	logic              done;
	rsp_t              rsp;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	int                fail_count;
	int                pending;

	// Nonzero addresses handed out and not yet freed, kept so frees mostly hit.
	logic [SIZE_W-1:0] live_addr [$];
	logic [SIZE_W-1:0] mem_total;
	int                gap_pct;

	first_fit_partition_allocator_top #(.MAX_PARTS(MAX_PARTS), .ADDR_BITS(16)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	ffpa_checker #(.MAX_PARTS(MAX_PARTS)) chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: far beyond the slowest run of about 1500 items plus gaps.
	initial begin
		#(12 * 2000000);
		$display("Mismatches found");
		$finish;
	end

	// Track grants so later frees can name live partitions.
	always @(posedge clk) begin
		if (done && rsp.status == ST_OK && rsp.alloc_addr != 0)
			live_addr.insert(live_addr.size(), rsp.alloc_addr);
	end

	// Present one item and hold it until accepted; start stays high for a
	// back-to-back item and drops only while idling.
	task automatic send_item(logic f, logic [SIZE_W-1:0] sz, logic [SIZE_W-1:0] fa);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req.func <= f;
		req.request_size <= sz;
		req.free_addr <= fa;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (3 * MAX_PARTS + 20) @(posedge clk);
	endtask

	task automatic write_total(logic [SIZE_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		mem_total = v;
		live_addr.delete();
	endtask

	task automatic free_live();
		int k;
		logic [SIZE_W-1:0] a;
		if (live_addr.size() == 0) begin
			send_item(FUNC_FREE, 16'($urandom), 16'd0);
		end else begin
			k = $urandom_range(live_addr.size() - 1);
			a = live_addr[k];
			live_addr.delete(k);
			send_item(FUNC_FREE, 16'($urandom), a);
		end
	endtask

	// Random phase: mostly sized allocates and live frees, with some noise.
	task automatic random_phase(int n);
		int r;
		logic [SIZE_W-1:0] sz;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 50) begin
				if ($urandom_range(9) == 0)
					sz = 16'($urandom);
				else
					sz = 16'($urandom_range(1, (mem_total > 0 ? mem_total : 1) / 8 + 1));
				send_item(FUNC_ALLOC, sz, 16'($urandom));
			end else if (r < 90) begin
				free_live();
			end else begin
				send_item(FUNC_FREE, 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mem_total = 16'd1024;
		gap_pct = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero size, too large, exact fit, split, bad frees, merges.
		send_item(FUNC_ALLOC, 16'd0, 16'hFFFF);
		send_item(FUNC_ALLOC, 16'hFFFF, 16'd0);
		send_item(FUNC_ALLOC, 16'd100, 16'd0);
		send_item(FUNC_ALLOC, 16'd200, 16'd0);
		send_item(FUNC_ALLOC, 16'd724, 16'd0);
		send_item(FUNC_ALLOC, 16'd1, 16'd0);
		send_item(FUNC_FREE, 16'd0, 16'd5);
		send_item(FUNC_FREE, 16'hFFFF, 16'd100);
		send_item(FUNC_FREE, 16'd0, 16'd100);
		send_item(FUNC_FREE, 16'd0, 16'd0);
		send_item(FUNC_FREE, 16'd0, 16'd300);
		send_item(FUNC_FREE, 16'd0, 16'hFFFF);
		// Fill the table with unit splits, then a split must report full.
		write_total(16'd40);
		for (int i = 0; i < MAX_PARTS; i++) send_item(FUNC_ALLOC, 16'd1, 16'd0);
		send_item(FUNC_FREE, 16'd0, 16'd3);
		send_item(FUNC_ALLOC, 16'd2, 16'd0);
		send_item(FUNC_ALLOC, 16'd1, 16'd0);
		// Zero total size: every allocate fails.
		write_total(16'd0);
		send_item(FUNC_ALLOC, 16'd1, 16'd0);
		write_total(16'hFFFF);
		send_item(FUNC_ALLOC, 16'hFFFF, 16'd0);
		send_item(FUNC_FREE, 16'd0, 16'd0);

		// Hold off until everything is back, then random phases.
		drain();
		write_total(16'd1024);
		gap_pct = 35;
		random_phase(450);
		write_total(16'd1);
		random_phase(30);
		write_total(16'd300);
		gap_pct = 72;
		random_phase(450);
		write_total(16'hFFFF);
		gap_pct = 0;
		random_phase(450);
		write_total(16'd64);
		random_phase(70);

		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
